@@ rtl/mi_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mi_pkg;

    localparam int FIELD_W = 31;

    typedef enum logic [2:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_DIV,
        CMD_REDUCE,
        CMD_SETUP,
        CMD_UPDATE,
        CMD_FINISH
    } dp_cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_A,
        S_REDUCE,
        S_TEST,
        S_DIV,
        S_UPDATE,
        S_FIN
    } state_t;

    typedef struct packed {
        logic r1_zero;
        logic div_last;
    } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/modular_inverse.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Modular inverse by the extended Euclidean algorithm, one operand pair at a time.
// Each Euclid quotient step is a bit-serial division of W = min(WORD_BITS-1, 31) bits;
// the value is first reduced modulo the modulus by one such division.
// A new pair is taken only when idle; a new start is taken in the cycle done shows.
// The result beat is held for one cycle under done; the receiver cannot stall.
// Reset clears the controller and the result registers; operands need no reset.

module modular_inverse
    import mi_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [FIELD_W-1:0] value,
    input  wire logic [FIELD_W-1:0] modulus,
    output logic                    done,
    output logic      [FIELD_W-1:0] inverse,
    output logic                    not_invertible
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mi_datapath #(
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .value          (value),
        .modulus        (modulus),
        .status         (status),
        .inverse        (inverse),
        .not_invertible (not_invertible)
    );

endmodule

`default_nettype wire

@@ rtl/mi_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mi_ctrl
    import mi_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd,
    output logic            busy,
    output logic            done
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_IDLE;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DIV_A;
                end
            end
            S_DIV_A:
            begin
                cmd = CMD_DIV;
                if (status.div_last)
                begin
                    state_next = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                cmd        = CMD_REDUCE;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                // stop once the remainder sequence reaches zero
                if (status.r1_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = CMD_SETUP;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd = CMD_DIV;
                if (status.div_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd        = CMD_UPDATE;
                state_next = S_TEST;
            end
            S_FIN:
            begin
                cmd        = CMD_FINISH;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

@@ rtl/mi_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mi_datapath
    import mi_pkg::*;
#(
    parameter int WORD_BITS = 32
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire logic [FIELD_W-1:0] value,
    input  wire logic [FIELD_W-1:0] modulus,
    output dp_status_t              status,
    output logic      [FIELD_W-1:0] inverse,
    output logic                    not_invertible
);

    localparam int OW = (WORD_BITS - 1 < FIELD_W) ? WORD_BITS - 1 : FIELD_W;
    localparam int TW = OW + 2;
    localparam int CW = $clog2(OW);

    logic        [OW-1:0]      m_reg;
    logic        [OW-1:0]      r0_reg;
    logic        [OW-1:0]      r1_reg;
    logic        [OW-1:0]      rem_reg;
    logic        [OW-1:0]      quo_reg;
    logic signed [TW-1:0]      t0_reg;
    logic signed [TW-1:0]      t1_reg;
    logic signed [TW-1:0]      acc_reg;
    logic        [CW-1:0]      cnt_reg;
    logic        [FIELD_W-1:0] inv_reg;
    logic                      fail_reg;

    logic        [OW:0]        rem_sh;
    logic        [OW:0]        rem_diff;
    logic                      qbit;
    logic signed [TW-1:0]      acc_step;
    logic signed [TW-1:0]      t0_fix;
    logic                      fail_now;

    // one restoring division step: bring down the next dividend bit
    assign rem_sh   = {rem_reg, quo_reg[OW-1]};
    assign rem_diff = rem_sh - {1'b0, r1_reg};
    assign qbit     = (rem_sh >= {1'b0, r1_reg});
    // build q*t1 alongside, MSB of q first
    assign acc_step = (acc_reg <<< 1) + (qbit ? t1_reg : TW'(0));

    assign t0_fix   = t0_reg[TW-1] ? (t0_reg + $signed({2'b00, m_reg})) : t0_reg;
    assign fail_now = (m_reg == '0) || (r0_reg != OW'(1));

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                m_reg   <= modulus[OW-1:0];
                r0_reg  <= modulus[OW-1:0];
                r1_reg  <= modulus[OW-1:0];
                quo_reg <= value[OW-1:0];
                rem_reg <= '0;
                acc_reg <= '0;
                cnt_reg <= '0;
                t0_reg  <= '0;
                t1_reg  <= TW'(1);
            end
            CMD_DIV:
            begin
                rem_reg <= qbit ? rem_diff[OW-1:0] : rem_sh[OW-1:0];
                quo_reg <= {quo_reg[OW-2:0], qbit};
                acc_reg <= acc_step;
                cnt_reg <= cnt_reg + CW'(1);
            end
            CMD_REDUCE:
            begin
                r1_reg <= rem_reg;
            end
            CMD_SETUP:
            begin
                quo_reg <= r0_reg;
                rem_reg <= '0;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            CMD_UPDATE:
            begin
                r0_reg <= r1_reg;
                r1_reg <= rem_reg;
                t0_reg <= t1_reg;
                t1_reg <= t0_reg - acc_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg  <= '0;
            fail_reg <= 1'b0;
        end
        else if (cmd == CMD_FINISH)
        begin
            fail_reg <= fail_now;
            inv_reg  <= fail_now ? '0 : FIELD_W'(t0_fix[OW-1:0]);
        end
    end

    assign status.r1_zero  = (r1_reg == '0);
    assign status.div_last = (cnt_reg == CW'(OW - 1));
    assign inverse         = inv_reg;
    assign not_invertible  = fail_reg;

endmodule

`default_nettype wire
